// File: hdl/rebd_pkg.sv
// Shared types and constants for the rotary encoder / button decoder.
// No dependencies; compiled first.
package rebd_pkg;

    // Event codes returned on a read transaction.
    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_PRESS = 2'd1,
        EV_DOWN  = 2'd2,
        EV_UP    = 2'd3
    } t_event;

    localparam logic [7:0] DEBOUNCE_TICKS_RESET = 8'd10;
    localparam logic [1:0] AB_RESET             = 2'b11;
    localparam logic [7:0] PRESS_MAX            = 8'hff;
    localparam logic signed [3:0] SUB_LIMIT     = 4'sd3;

    // Quadrature step indexed by {previous A, previous B, new A, new B}.
    localparam logic signed [1:0] STEP_TABLE [16] = '{
        2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd0, -2'sd1,
        -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0
    };

    // One registered input sample.
    typedef struct packed {
        logic enc_a;
        logic enc_b;
        logic button_pin;
        logic tick;
        logic read_event;
        logic discard_all;
    } t_item;

    typedef struct packed {
        logic fire;
        logic pin_change;
        logic clr_turn;
    } t_quad_ctrl;

    typedef struct packed {
        logic ab_diff;
        logic turn_neg;
        logic turn_pos;
    } t_quad_stat;

    typedef struct packed {
        logic fire;
        logic pin_change;
        logic clr_press;
    } t_btn_ctrl;

    typedef struct packed {
        logic btn_diff;
        logic press_nz;
        logic pressed;
    } t_btn_stat;

endpackage

// File: hdl/rebd_in_if.sv
// Input sample channel: valid/ready handshake plus pin and strobe levels.
// No dependencies.
interface rebd_in_if;
    logic valid;
    logic ready;
    logic enc_a;
    logic enc_b;
    logic button_pin;
    logic tick;
    logic read_event;
    logic discard_all;

    modport source (output valid, enc_a, enc_b, button_pin, tick, read_event, discard_all,
                    input ready);
    modport sink   (input valid, enc_a, enc_b, button_pin, tick, read_event, discard_all,
                    output ready);
endinterface

// File: hdl/rebd_out_if.sv
// Result channel: valid/ready handshake plus event code and button state.
// No dependencies.
interface rebd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_code;
    logic       button_pressed;

    modport source (output valid, event_code, button_pressed, input ready);
    modport sink   (input valid, event_code, button_pressed, output ready);
endinterface

// File: hdl/rebd_quad.sv
// Quadrature decoder: A/B history, substate and saturating turn count.
// Depends on rebd_pkg.
module rebd_quad #(
    parameter int TURN_COUNT_WIDTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rebd_pkg::t_item       i_item,
    input  rebd_pkg::t_quad_ctrl  i_ctrl,
    output rebd_pkg::t_quad_stat  o_stat
);
    localparam logic signed [TURN_COUNT_WIDTH-1:0] TURN_MAX =
        {1'b0, {(TURN_COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [TURN_COUNT_WIDTH-1:0] TURN_MIN = -TURN_MAX;

    logic [3:0]                         r_hist, n_hist;
    logic signed [3:0]                  r_sub, n_sub;
    logic signed [TURN_COUNT_WIDTH-1:0] r_turn, n_turn;
    logic signed [1:0]                  step;
    logic signed [3:0]                  sub_sum;

    always_comb begin
        n_hist  = r_hist;
        n_sub   = r_sub;
        n_turn  = r_turn;
        step    = rebd_pkg::STEP_TABLE[{r_hist[1:0], i_item.enc_a, i_item.enc_b}];
        sub_sum = r_sub + {{2{step[1]}}, step};
        if (i_ctrl.pin_change) begin
            n_hist = {r_hist[1:0], i_item.enc_a, i_item.enc_b};
            n_sub  = sub_sum;
            if (sub_sum > rebd_pkg::SUB_LIMIT) begin
                if (r_turn < TURN_MAX) n_turn = r_turn + 1'b1;
                n_sub = '0;
            end else if (sub_sum < -rebd_pkg::SUB_LIMIT) begin
                if (r_turn > TURN_MIN) n_turn = r_turn - 1'b1;
                n_sub = '0;
            end
        end
    end

    assign o_stat.ab_diff  = ({i_item.enc_a, i_item.enc_b} != r_hist[1:0]);
    assign o_stat.turn_neg = n_turn[TURN_COUNT_WIDTH-1];
    assign o_stat.turn_pos = !n_turn[TURN_COUNT_WIDTH-1] && (n_turn != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= {2'b00, rebd_pkg::AB_RESET};
            r_sub  <= '0;
            r_turn <= '0;
        end else if (i_ctrl.fire) begin
            r_hist <= n_hist;
            r_sub  <= n_sub;
            r_turn <= i_ctrl.clr_turn ? '0 : n_turn;
        end
    end
endmodule

// File: hdl/rebd_button.sv
// Button debouncer: tick countdown, debounced state, saturating press count.
// Depends on rebd_pkg.
module rebd_button (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0]           i_debounce_ticks,
    input  rebd_pkg::t_item      i_item,
    input  rebd_pkg::t_btn_ctrl  i_ctrl,
    output rebd_pkg::t_btn_stat  o_stat
);
    logic       r_deb, n_deb;
    logic [7:0] r_rem, n_rem, rem_mid;
    logic [7:0] r_press, n_press;
    logic       r_last;

    always_comb begin
        rem_mid = r_rem;
        if (i_ctrl.pin_change)
            rem_mid = (!i_item.button_pin == r_deb) ? 8'd0 : i_debounce_ticks;
        n_rem   = rem_mid;
        n_deb   = r_deb;
        n_press = r_press;
        if (i_item.tick && rem_mid != 8'd0) begin
            n_rem = rem_mid - 8'd1;
            if (rem_mid == 8'd1) begin
                n_deb = !r_deb;
                if (!r_deb && r_press != rebd_pkg::PRESS_MAX) n_press = r_press + 8'd1;
            end
        end
    end

    assign o_stat.btn_diff = (i_item.button_pin != r_last);
    assign o_stat.press_nz = (n_press != 8'd0);
    assign o_stat.pressed  = n_deb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb   <= 1'b0;
            r_rem   <= '0;
            r_press <= '0;
            r_last  <= 1'b1;
        end else if (i_ctrl.fire) begin
            r_deb   <= n_deb;
            r_rem   <= n_rem;
            r_press <= i_ctrl.clr_press ? 8'd0 : n_press;
            r_last  <= i_item.button_pin;
        end
    end
endmodule

// File: hdl/rotary_encoder_button_decoder.sv
// Top level of the rotary encoder / button decoder.
// Depends on rebd_pkg, rebd_in_if, rebd_out_if, rebd_quad, rebd_button.
//
//  Channel   Dir  Handshake        Payload
//  i_item    in   valid/ready      enc_a, enc_b, button_pin, tick, read_event, discard_all
//  o_result  out  valid/ready      event_code[1:0], button_pressed
//  i_cfg_*   in   write enable     debounce_ticks[7:0]
//
// One transaction per clock cycle sustained while o_result.ready stays high. The
// sample lands in the input register, then the quadrature and debounce updates
// run in one pass into the result register. Reset is synchronous, active low.
// When the result register is held by o_result.ready low, the input register
// holds and i_item.ready drops only if the input register is also full.
module rotary_encoder_button_decoder #(
    parameter int TURN_COUNT_WIDTH = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    rebd_in_if.sink    i_item,
    rebd_out_if.source o_result
);
    logic                 r_in_valid;
    rebd_pkg::t_item      r_item;
    logic                 r_out_valid;
    rebd_pkg::t_event     r_event, n_event;
    logic                 r_pressed;
    logic [7:0]           r_debounce_ticks;

    logic                 advance;
    logic                 fire;
    logic                 pin_change;
    logic                 clr_press;
    logic                 clr_turn;
    rebd_pkg::t_quad_ctrl quad_ctrl;
    rebd_pkg::t_quad_stat quad_stat;
    rebd_pkg::t_btn_ctrl  btn_ctrl;
    rebd_pkg::t_btn_stat  btn_stat;

    // Pipeline moves when the result slot is free or being drained.
    assign advance       = !r_out_valid || o_result.ready;
    assign fire          = r_in_valid && advance;
    assign i_item.ready  = !r_in_valid || advance;

    // Config register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks <= rebd_pkg::DEBOUNCE_TICKS_RESET;
        end else if (i_cfg_we) begin
            r_debounce_ticks <= i_cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_item <= '{enc_a:       i_item.enc_a,
                        enc_b:       i_item.enc_b,
                        button_pin:  i_item.button_pin,
                        tick:        i_item.tick,
                        read_event:  i_item.read_event,
                        discard_all: i_item.discard_all};
        end
    end

    // Any pin change runs both the quadrature and debounce restart logic.
    assign pin_change = quad_stat.ab_diff || btn_stat.btn_diff;

    // Read priority: press, then down, then up. Discard wipes both counts after.
    always_comb begin
        n_event = rebd_pkg::EV_NONE;
        if (r_item.read_event) begin
            if (btn_stat.press_nz)       n_event = rebd_pkg::EV_PRESS;
            else if (quad_stat.turn_neg) n_event = rebd_pkg::EV_DOWN;
            else if (quad_stat.turn_pos) n_event = rebd_pkg::EV_UP;
        end
    end

    assign clr_press = (r_item.read_event && btn_stat.press_nz) || r_item.discard_all;
    assign clr_turn  = (r_item.read_event && !btn_stat.press_nz) || r_item.discard_all;

    assign quad_ctrl = '{fire: fire, pin_change: pin_change, clr_turn: clr_turn};
    assign btn_ctrl  = '{fire: fire, pin_change: pin_change, clr_press: clr_press};

    rebd_quad #(
        .TURN_COUNT_WIDTH(TURN_COUNT_WIDTH)
    ) u_quad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (r_item),
        .i_ctrl  (quad_ctrl),
        .o_stat  (quad_stat)
    );

    rebd_button u_button (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_debounce_ticks (r_debounce_ticks),
        .i_item           (r_item),
        .i_ctrl           (btn_ctrl),
        .o_stat           (btn_stat)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_event   <= n_event;
            r_pressed <= btn_stat.pressed;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.event_code     = r_event;
    assign o_result.button_pressed = r_pressed;
endmodule
